FILE: design/lzw_byte_stream_compressor_macros.svh
// assertion macros for the lzw byte stream compressor
// used by the top level, expects clk and rst_n in scope
`ifndef LZW_BYTE_STREAM_COMPRESSOR_MACROS_SVH
`define LZW_BYTE_STREAM_COMPRESSOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LBSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbsc check failed");

// antecedent implies consequent in the following cycle
`define LBSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbsc check failed");

`endif

FILE: design/lbsc_pkg.sv
// shared constants and types of the lzw byte stream compressor
// no dependencies
package lbsc_pkg;

    localparam int DICT_ENTRIES  = 4096;
    localparam int MAX_CODE_BITS = 12;
    localparam int CODE_W        = $clog2(DICT_ENTRIES);
    localparam int NFC_W         = CODE_W + 1;
    localparam int WIDTH_W       = $clog2(MAX_CODE_BITS + 1);
    localparam int ACC_W         = MAX_CODE_BITS + 8;
    localparam int CNT_W         = $clog2(ACC_W + 1);
    localparam int ROOT_CODES    = 256;
    localparam int FIRST_WIDTH   = 8;

    localparam logic [CODE_W-1:0] NO_PREFIX = CODE_W'(DICT_ENTRIES - 1);

    // one accepted input request
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } lbsc_item_t;

    // packing command from the engine to the packer
    typedef struct packed {
        logic               c1_en;
        logic [CODE_W-1:0]  c1;
        logic [WIDTH_W-1:0] w1;
        logic               c2_en;
        logic [CODE_W-1:0]  c2;
        logic [WIDTH_W-1:0] w2;
        logic               finish;
        logic               status;
    } lbsc_cmd_t;

endpackage

FILE: design/lzw_byte_stream_compressor.sv
// Streaming LZW compressor: takes one byte per request and returns the packed
// variable-width code stream, codes msb-first, starting at 8 bits and growing
// up to 12 as the 4096-entry dictionary fills. A request marked tlast ends the
// stream: the final code is written and padded with zeros to a byte boundary,
// that byte carrying the done flag. When the dictionary fills, the stream is
// ended at once with the status flag set on every byte of that request and
// further bytes are dropped until a tlast request. Children of the current
// prefix are found by a linear scan of the dictionary memory from prefix+1
// up to the next free code through its single read port; the packer puts
// out the bytes of each command as the output takes them, behind a two-entry
// input queue and a one-command hand-off, and takes a new command only when
// done with the last, so the engine and the output stall separately.
// Depends on lbsc_pkg, lbsc_front, lbsc_engine, lbsc_packer and the macro header.
`include "lzw_byte_stream_compressor_macros.svh"

module lzw_byte_stream_compressor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // last_of_run
    output logic [1:0] m_axis_tuser    // [0] stream_done, [1] status
);

    lbsc_pkg::lbsc_item_t in_item;
    lbsc_pkg::lbsc_item_t q_item;
    logic                 q_valid;
    logic                 q_pop;
    lbsc_pkg::lbsc_cmd_t  cmd;
    logic                 cmd_valid;
    logic                 cmd_ready;
    logic                 out_done;
    logic                 out_status;

    assign in_item.data = s_axis_tdata;
    assign in_item.eos  = s_axis_tlast;

    // front: request queue
    lbsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: dictionary search and update
    lbsc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // back: bit packing and output register
    lbsc_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_done   (out_done),
        .out_status (out_status)
    );

    assign m_axis_tuser = {out_status, out_done};

    // the end of a stream always closes the run of its request
    `LBSC_ASSERT_NOW(a_done_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
    // a waiting packing command holds until taken
    `LBSC_ASSERT_NEXT(a_cmd_hold, cmd_valid && !cmd_ready, cmd_valid && $stable(cmd))
    // an accepted request is queued for the engine
    `LBSC_ASSERT_NEXT(a_in_queued, s_axis_tvalid && s_axis_tready, q_valid)

endmodule

FILE: design/lbsc_front.sv
// input side: accepts requests into a two-entry queue
// depends on lbsc_pkg
module lbsc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lbsc_pkg::lbsc_item_t in_item,
    output logic                q_valid,
    output lbsc_pkg::lbsc_item_t q_item,
    input  logic                q_pop
);

    lbsc_pkg::lbsc_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: design/lbsc_engine.sv
// dictionary engine: child search, insertion, width growth, stream end
// depends on lbsc_pkg
module lbsc_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  lbsc_pkg::lbsc_item_t q_item,
    output logic                 q_pop,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output lbsc_pkg::lbsc_cmd_t  cmd
);

    typedef enum logic [4:0] {
        E_IDLE = 5'b00001,
        E_LOOK = 5'b00010,
        E_READ = 5'b00100,
        E_CMP  = 5'b01000,
        E_SEND = 5'b10000
    } lbsc_estate_t;

    lbsc_estate_t state_reg, state_next;
    logic [lbsc_pkg::CODE_W-1:0]  prefix_reg, prefix_next;
    logic [lbsc_pkg::NFC_W-1:0]   nfc_reg, nfc_next;
    logic [lbsc_pkg::WIDTH_W-1:0] width_reg, width_next;
    logic                         halted_reg, halted_next;
    logic [7:0]                   byte_reg, byte_next;
    logic                         eos_reg, eos_next;
    logic [lbsc_pkg::CODE_W-1:0]  k_reg, k_next;
    logic                         cmd_valid_reg, cmd_valid_next;
    lbsc_pkg::lbsc_cmd_t          cmd_reg, cmd_next;

    logic [lbsc_pkg::CODE_W+7:0]  dict_mem [lbsc_pkg::DICT_ENTRIES];
    logic [lbsc_pkg::CODE_W+7:0]  rd_data_reg;
    logic                         mem_we;

    logic [lbsc_pkg::NFC_W-1:0]   nfc_inc;
    logic                         width_grow;
    logic [lbsc_pkg::WIDTH_W-1:0] width_inc;
    logic                         full;
    logic                         range_empty;
    logic                         k_last;
    logic                         entry_match;

    assign nfc_inc     = nfc_reg + lbsc_pkg::NFC_W'(1);
    assign width_grow  = (width_reg < lbsc_pkg::WIDTH_W'(lbsc_pkg::MAX_CODE_BITS))
                         && (nfc_inc > (lbsc_pkg::NFC_W'(1) << width_reg));
    assign width_inc   = width_grow ? width_reg + lbsc_pkg::WIDTH_W'(1) : width_reg;
    assign full        = nfc_inc >= lbsc_pkg::NFC_W'(lbsc_pkg::DICT_ENTRIES);
    assign range_empty = (lbsc_pkg::NFC_W'(prefix_reg) + lbsc_pkg::NFC_W'(1)) >= nfc_reg;
    assign k_last      = (lbsc_pkg::NFC_W'(k_reg) + lbsc_pkg::NFC_W'(1)) >= nfc_reg;
    assign entry_match = (rd_data_reg == {prefix_reg, byte_reg});

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        logic do_hit;
        logic do_miss;
        logic do_clear;

        do_hit         = 1'b0;
        do_miss        = 1'b0;
        do_clear       = 1'b0;
        state_next     = state_reg;
        prefix_next    = prefix_reg;
        nfc_next       = nfc_reg;
        width_next     = width_reg;
        halted_next    = halted_reg;
        byte_next      = byte_reg;
        eos_next       = eos_reg;
        k_next         = k_reg;
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;

        unique case (state_reg)
            E_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    byte_next  = q_item.data;
                    eos_next   = q_item.eos;
                    state_next = E_LOOK;
                end
            end
            E_LOOK:
            begin
                cmd_next = '0;
                if (halted_reg)
                begin
                    do_clear   = eos_reg;
                    state_next = E_IDLE;
                end
                else if (prefix_reg == lbsc_pkg::NO_PREFIX)
                begin
                    prefix_next = lbsc_pkg::CODE_W'(byte_reg);
                    if (eos_reg)
                    begin
                        cmd_next.c2_en  = 1'b1;
                        cmd_next.c2     = lbsc_pkg::CODE_W'(byte_reg);
                        cmd_next.w2     = width_reg;
                        cmd_next.finish = 1'b1;
                        do_clear        = 1'b1;
                        cmd_valid_next  = 1'b1;
                        state_next      = E_SEND;
                    end
                    else
                    begin
                        state_next = E_IDLE;
                    end
                end
                else if (range_empty)
                begin
                    do_miss = 1'b1;
                end
                else
                begin
                    k_next     = prefix_reg + lbsc_pkg::CODE_W'(1);
                    state_next = E_READ;
                end
            end
            E_READ:
            begin
                state_next = E_CMP;
            end
            E_CMP:
            begin
                if (entry_match)
                begin
                    do_hit = 1'b1;
                end
                else if (k_last)
                begin
                    do_miss = 1'b1;
                end
                else
                begin
                    k_next     = k_reg + lbsc_pkg::CODE_W'(1);
                    state_next = E_READ;
                end
            end
            E_SEND:
            begin
                if (cmd_ready)
                begin
                    cmd_valid_next = 1'b0;
                    state_next     = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase

        // matching child extends the current string
        if (do_hit)
        begin
            prefix_next = k_reg;
            if (eos_reg)
            begin
                cmd_next.c2_en  = 1'b1;
                cmd_next.c2     = k_reg;
                cmd_next.w2     = width_reg;
                cmd_next.finish = 1'b1;
                do_clear        = 1'b1;
                cmd_valid_next  = 1'b1;
                state_next      = E_SEND;
            end
            else
            begin
                state_next = E_IDLE;
            end
        end

        // no child: emit prefix, insert new entry
        if (do_miss)
        begin
            mem_we         = 1'b1;
            cmd_next.c1_en = 1'b1;
            cmd_next.c1    = prefix_reg;
            cmd_next.w1    = width_reg;
            nfc_next       = nfc_inc;
            width_next     = width_inc;
            if (full)
            begin
                cmd_next.c2_en  = 1'b1;
                cmd_next.c2     = prefix_reg;
                cmd_next.w2     = width_inc;
                cmd_next.finish = 1'b1;
                cmd_next.status = 1'b1;
                if (eos_reg)
                begin
                    do_clear = 1'b1;
                end
                else
                begin
                    halted_next = 1'b1;
                end
            end
            else
            begin
                prefix_next = lbsc_pkg::CODE_W'(byte_reg);
                if (eos_reg)
                begin
                    cmd_next.c2_en  = 1'b1;
                    cmd_next.c2     = lbsc_pkg::CODE_W'(byte_reg);
                    cmd_next.w2     = width_inc;
                    cmd_next.finish = 1'b1;
                    do_clear        = 1'b1;
                end
            end
            cmd_valid_next = 1'b1;
            state_next     = E_SEND;
        end

        if (do_clear)
        begin
            prefix_next = lbsc_pkg::NO_PREFIX;
            nfc_next    = lbsc_pkg::NFC_W'(lbsc_pkg::ROOT_CODES);
            width_next  = lbsc_pkg::WIDTH_W'(lbsc_pkg::FIRST_WIDTH);
            halted_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            prefix_reg    <= lbsc_pkg::NO_PREFIX;
            nfc_reg       <= lbsc_pkg::NFC_W'(lbsc_pkg::ROOT_CODES);
            width_reg     <= lbsc_pkg::WIDTH_W'(lbsc_pkg::FIRST_WIDTH);
            halted_reg    <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            nfc_reg       <= nfc_next;
            width_reg     <= width_next;
            halted_reg    <= halted_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        eos_reg  <= eos_next;
        k_reg    <= k_next;
        cmd_reg  <= cmd_next;
    end

    // dictionary memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dict_mem[nfc_reg[lbsc_pkg::CODE_W-1:0]] <= {prefix_reg, byte_reg};
        end
        rd_data_reg <= dict_mem[k_reg];
    end

endmodule

FILE: design/lbsc_packer.sv
// bit packer: msb-first code packing, padding and output register
// depends on lbsc_pkg
module lbsc_packer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  lbsc_pkg::lbsc_cmd_t cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_data,
    output logic                out_last,
    output logic                out_done,
    output logic                out_status
);

    typedef enum logic [2:0] {
        P_IDLE  = 3'b001,
        P_STEP  = 3'b010,
        P_DRAIN = 3'b100
    } lbsc_pstate_t;

    lbsc_pstate_t state_reg, state_next;
    lbsc_pkg::lbsc_cmd_t          cmd_reg, cmd_next;
    logic                         c1p_reg, c1p_next;
    logic                         c2p_reg, c2p_next;
    logic                         padp_reg, padp_next;
    logic [lbsc_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [lbsc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]                   held_reg, held_next;
    logic                         held_valid_reg, held_valid_next;
    logic                         ov_reg, ov_next;
    logic [7:0]                   od_reg, od_next;
    logic                         ol_reg, ol_next;
    logic                         odone_reg, odone_next;
    logic                         ost_reg, ost_next;
    logic                         out_free;
    logic [lbsc_pkg::ACC_W-1:0]   v1;
    logic [lbsc_pkg::ACC_W-1:0]   v2;

    assign out_free   = !ov_reg || out_ready;
    assign cmd_ready  = (state_reg == P_IDLE);
    assign out_valid  = ov_reg;
    assign out_data   = od_reg;
    assign out_last   = ol_reg;
    assign out_done   = odone_reg;
    assign out_status = ost_reg;

    assign v1 = lbsc_pkg::ACC_W'(cmd_reg.c1)
                & ((lbsc_pkg::ACC_W'(1) << cmd_reg.w1) - lbsc_pkg::ACC_W'(1));
    assign v2 = lbsc_pkg::ACC_W'(cmd_reg.c2)
                & ((lbsc_pkg::ACC_W'(1) << cmd_reg.w2) - lbsc_pkg::ACC_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        c1p_next        = c1p_reg;
        c2p_next        = c2p_reg;
        padp_next       = padp_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        ov_next         = ov_reg && !out_ready;
        od_next         = od_reg;
        ol_next         = ol_reg;
        odone_next      = odone_reg;
        ost_next        = ost_reg;

        unique case (state_reg)
            P_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    c1p_next   = cmd.c1_en;
                    c2p_next   = cmd.c2_en;
                    padp_next  = cmd.finish;
                    state_next = P_STEP;
                end
            end
            P_STEP:
            begin
                if (c1p_reg)
                begin
                    acc_next   = (acc_reg << cmd_reg.w1) | v1;
                    cnt_next   = cnt_reg + lbsc_pkg::CNT_W'(cmd_reg.w1);
                    c1p_next   = 1'b0;
                    state_next = P_DRAIN;
                end
                else if (c2p_reg)
                begin
                    acc_next   = (acc_reg << cmd_reg.w2) | v2;
                    cnt_next   = cnt_reg + lbsc_pkg::CNT_W'(cmd_reg.w2);
                    c2p_next   = 1'b0;
                    state_next = P_DRAIN;
                end
                else if (padp_reg)
                begin
                    padp_next = 1'b0;
                    if (cnt_reg != '0)
                    begin
                        acc_next   = acc_reg << (lbsc_pkg::CNT_W'(8) - cnt_reg);
                        cnt_next   = lbsc_pkg::CNT_W'(8);
                        state_next = P_DRAIN;
                    end
                end
                else if (!held_valid_reg || out_free)
                begin
                    // release the held byte as the last of this request
                    if (held_valid_reg)
                    begin
                        ov_next    = 1'b1;
                        od_next    = held_reg;
                        ol_next    = 1'b1;
                        odone_next = cmd_reg.finish;
                        ost_next   = cmd_reg.status;
                    end
                    held_valid_next = 1'b0;
                    if (cmd_reg.finish)
                    begin
                        acc_next = '0;
                        cnt_next = '0;
                    end
                    state_next = P_IDLE;
                end
            end
            P_DRAIN:
            begin
                if (cnt_reg >= lbsc_pkg::CNT_W'(8))
                begin
                    if (!held_valid_reg || out_free)
                    begin
                        if (held_valid_reg)
                        begin
                            ov_next    = 1'b1;
                            od_next    = held_reg;
                            ol_next    = 1'b0;
                            odone_next = 1'b0;
                            ost_next   = cmd_reg.status;
                        end
                        held_next       = 8'(acc_reg >> (cnt_reg - lbsc_pkg::CNT_W'(8)));
                        held_valid_next = 1'b1;
                        cnt_next        = cnt_reg - lbsc_pkg::CNT_W'(8);
                    end
                end
                else
                begin
                    state_next = P_STEP;
                end
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= P_IDLE;
            c1p_reg        <= 1'b0;
            c2p_reg        <= 1'b0;
            padp_reg       <= 1'b0;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            held_valid_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            c1p_reg        <= c1p_next;
            c2p_reg        <= c2p_next;
            padp_reg       <= padp_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            held_valid_reg <= held_valid_next;
            ov_reg         <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        held_reg  <= held_next;
        od_reg    <= od_next;
        ol_reg    <= ol_next;
        odone_reg <= odone_next;
        ost_reg   <= ost_next;
    end

endmodule

FILE: tb/lzw_byte_stream_compressor_checker.sv
// checker for the lzw byte stream compressor: watches both stream channels,
// predicts the packed code bytes of every accepted request and compares them
// depends on lbsc_pkg
module lzw_byte_stream_compressor_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    input  logic [1:0] m_axis_tuser,
    output int         failures,
    output int         outstanding,
    output int         bytes_checked,
    output int         full_streams
);

    typedef struct packed {
        logic [7:0] data;
        logic       last_of_run;
        logic       done;
        logic       status;
    } code_byte_t;

    logic [lbsc_pkg::CODE_W-1:0] dict_prefix [lbsc_pkg::DICT_ENTRIES];
    logic [7:0]                  dict_byte [lbsc_pkg::DICT_ENTRIES];
    int unsigned       free_code;
    int unsigned       code_bits;
    int unsigned       cur_prefix;
    int unsigned       bit_acc;
    int unsigned       acc_bits;
    bit                halted;

    code_byte_t step_bytes [$];
    code_byte_t expected_bytes [$];

    function automatic void restart_stream();
        free_code  = lbsc_pkg::ROOT_CODES;
        code_bits  = lbsc_pkg::FIRST_WIDTH;
        cur_prefix = lbsc_pkg::NO_PREFIX;
        bit_acc    = 0;
        acc_bits   = 0;
        halted     = 0;
    endfunction

    // msb-first packing into whole bytes
    function automatic void pack_code(int unsigned value, int unsigned w);
        code_byte_t b;
        bit_acc  = (bit_acc << w) | (value & ((32'd1 << w) - 1));
        acc_bits = acc_bits + w;
        while (acc_bits >= 8)
        begin
            acc_bits = acc_bits - 8;
            b = '0;
            b.data = 8'(bit_acc >> acc_bits);
            step_bytes.push_back(b);
        end
        bit_acc = bit_acc & ((32'd1 << acc_bits) - 1);
    endfunction

    function automatic int unsigned find_child(int unsigned p, logic [7:0] c);
        for (int unsigned k = p + 1; k < free_code && k < lbsc_pkg::DICT_ENTRIES; k++)
            if (dict_prefix[k] == lbsc_pkg::CODE_W'(p) && dict_byte[k] == c)
                return k;
        return lbsc_pkg::NO_PREFIX;
    endfunction

    function automatic void compress_byte(logic [7:0] c, logic eos);
        int unsigned hit;
        int unsigned n;
        bit          full;
        full = 0;
        step_bytes.delete();
        if (halted)
        begin
            if (eos)
                restart_stream();
            return;
        end
        if (cur_prefix == lbsc_pkg::NO_PREFIX)
            cur_prefix = c;
        else
        begin
            hit = find_child(cur_prefix, c);
            if (hit != lbsc_pkg::NO_PREFIX)
                cur_prefix = hit;
            else
            begin
                pack_code(cur_prefix, code_bits);
                dict_prefix[free_code % lbsc_pkg::DICT_ENTRIES] =
                    lbsc_pkg::CODE_W'(cur_prefix);
                dict_byte[free_code % lbsc_pkg::DICT_ENTRIES]   = c;
                free_code++;
                if (code_bits < lbsc_pkg::MAX_CODE_BITS && free_code > (32'd1 << code_bits))
                    code_bits++;
                if (free_code >= lbsc_pkg::DICT_ENTRIES)
                    full = 1;
                else
                    cur_prefix = c;
            end
        end
        if (full || eos)
        begin
            // final code then zero pad to a byte boundary
            pack_code(cur_prefix, code_bits);
            if (acc_bits % 8 != 0)
                pack_code(0, 8 - (acc_bits % 8));
            n = step_bytes.size();
            if (n > 0)
                step_bytes[n-1].done = 1;
            if (full)
            begin
                full_streams++;
                foreach (step_bytes[k])
                    step_bytes[k].status = 1;
            end
            if (full && !eos)
                halted = 1;
            else
                restart_stream();
        end
        n = step_bytes.size();
        if (n > 0)
            step_bytes[n-1].last_of_run = 1;
        foreach (step_bytes[k])
            expected_bytes.push_back(step_bytes[k]);
    endfunction

    initial
    begin
        failures      = 0;
        bytes_checked = 0;
        full_streams  = 0;
        restart_stream();
    end

    assign outstanding = expected_bytes.size();

    always @(posedge clk)
    begin
        code_byte_t exp_b;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                compress_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                bytes_checked++;
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected output byte %02h", m_axis_tdata);
                    failures++;
                end
                else
                begin
                    exp_b = expected_bytes.pop_front();
                    if (m_axis_tdata !== exp_b.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", exp_b.data, m_axis_tdata);
                        failures++;
                    end
                    if (m_axis_tlast !== exp_b.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               exp_b.last_of_run, m_axis_tlast);
                        failures++;
                    end
                    if (m_axis_tuser[0] !== exp_b.done)
                    begin
                        $error("stream_done: expected %0b, got %0b",
                               exp_b.done, m_axis_tuser[0]);
                        failures++;
                    end
                    if (m_axis_tuser[1] !== exp_b.status)
                    begin
                        $error("status: expected %0b, got %0b",
                               exp_b.status, m_axis_tuser[1]);
                        failures++;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/lzw_byte_stream_compressor_test.sv
// testbench top of the lzw byte stream compressor: clock, reset, request
// stimulus with idling and back-pressure, watchdog and verdict
// depends on lbsc_pkg, the block and lzw_byte_stream_compressor_checker
module lzw_byte_stream_compressor_test;

    localparam int WATCHDOG_LIMIT = 40000;  // a miss scans up to 4094 entries

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;

    int failures;
    int outstanding;
    int bytes_checked;
    int full_streams;
    int requests_sent;
    int streams_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int quiet_cycles;

    lzw_byte_stream_compressor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    lzw_byte_stream_compressor_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .outstanding   (outstanding),
        .bytes_checked (bytes_checked),
        .full_streams  (full_streams)
    );

    initial
    begin
        clk = 0;
        forever
        begin
            #4 clk = 1;
            #4 clk = 0;
        end
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles in which neither channel moves a request
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lzw_byte_stream_compressor_test: errors");
            $finish;
        end
    end

    // one input request, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
        if (eos)
            streams_sent++;
    endtask

    // small alphabets give repeated strings and dictionary hits
    task automatic send_stream(input int len, input int alphabet);
        logic [7:0] base;
        base = 8'($urandom_range(255));
        for (int i = 0; i < len; i++)
        begin
            if (alphabet >= 256)
                send_byte(8'($urandom_range(255)), i == len - 1);
            else
                send_byte(base + 8'($urandom_range(alphabet - 1)), i == len - 1);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int idle, input int stall, input int items);
        int n;
        int len;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        n = 0;
        while (n < items)
        begin
            len = $urandom_range(1, 30);
            if (len > items - n)
                len = items - n;
            case ($urandom_range(3))
                0:       send_stream(len, 256);
                1:       send_stream(len, 2);
                default: send_stream(len, $urandom_range(3, 12));
            endcase
            n += len;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        quiet_cycles   = 0;
        requests_sent  = 0;
        streams_sent   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-byte streams at both extremes, runs of one byte,
        // alternating extremes and a fresh stream straight after an end
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        for (int i = 0; i < 8; i++)
            send_byte(8'h61, i == 7);
        for (int i = 0; i < 6; i++)
            send_byte(i[0] ? 8'hFF : 8'h00, i == 5);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        drain();

        // random streams under each idling mix
        random_phase(0, 0, 45);
        random_phase(56, 0, 45);
        random_phase(0, 56, 45);
        random_phase(29, 29, 45);

        // long receiver hold-off while requests keep coming, then a full pause
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        send_stream(40, 256);
        drain();
        send_stream(20, 4);
        drain();

        repeat (50) @(posedge clk);
        $display("covered %0d requests in %0d streams, %0d output bytes checked",
                 requests_sent, streams_sent, bytes_checked);
        $display("including %0d stream(s) ended by a full dictionary", full_streams);
        if (failures == 0 && outstanding == 0)
            $display("lzw_byte_stream_compressor_test: clean");
        else
            $display("lzw_byte_stream_compressor_test: errors");
        $finish;
    end

endmodule
